### design/pbrs_pkg.sv
// ----------------------------------------------------------------------------
// pbrs_pkg: shared definitions for the priority bitmap ready scheduler
// Field widths, reset constants, request codes, beat types, table entry types
// and the small helpers that several files use.
// ----------------------------------------------------------------------------
package pbrs_pkg;

	// Sizes of the thread and priority spaces.
	localparam int NUM_THREADS    = 32;
	localparam int NUM_PRIORITIES = 8;
	localparam int TID_W          = 5;
	localparam int PRIO_W         = 3;

	// The idle thread sits at the least urgent priority.
	localparam logic [PRIO_W-1:0] IDLE_PRIO = PRIO_W'(NUM_PRIORITIES - 1);

	// Threads with a fixed role after reset.
	localparam logic [TID_W-1:0] IDLE_THREAD = TID_W'(0);
	localparam logic [TID_W-1:0] BOOT_THREAD = TID_W'(1);

	// Request codes.
	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_SCHED  = 2'd2
	} req_kind_t;

	// Request beat.
	typedef struct packed {
		logic [1:0]        req_type;
		logic [TID_W-1:0]  thread_id;
		logic [PRIO_W-1:0] priority_req;
	} req_t;

	// Result beat.
	typedef struct packed {
		logic              status;
		logic              switched;
		logic [TID_W-1:0]  prev_thread;
		logic [TID_W-1:0]  running_thread;
		logic [PRIO_W-1:0] top_priority;
		logic              preempt_ready;
	} rsp_t;

	// Queue table entry: head and tail of one ready queue.
	typedef struct packed {
		logic [TID_W-1:0] head;
		logic [TID_W-1:0] tail;
	} qent_t;

	// Thread table entry: links and priority of one thread.
	typedef struct packed {
		logic [TID_W-1:0]  next;
		logic [TID_W-1:0]  prev;
		logic [PRIO_W-1:0] prio;
	} tent_t;

	// Per-field write enables of the thread table.
	typedef struct packed {
		logic next;
		logic prev;
		logic prio;
	} twe_t;

	// Saturate a priority to the last queue.
	function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
		logic [PRIO_W-1:0] r;
		r = p;
		if ({1'b0, p} >= (PRIO_W + 1)'(NUM_PRIORITIES)) begin
			r = IDLE_PRIO;
		end
		return r;
	endfunction

	// Index of the lowest set bit, zero for an empty map.
	function automatic logic [PRIO_W-1:0] lowest_set(input logic [NUM_PRIORITIES-1:0] m);
		logic [PRIO_W-1:0] r;
		r = '0;
		for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = PRIO_W'(i);
			end
		end
		return r;
	endfunction

endpackage

### design/pbrs_qtab.sv
// ----------------------------------------------------------------------------
// pbrs_qtab: ready queue head/tail table
// One entry per priority, one write and one registered read per cycle. Entries
// read as zero until first written.
// ----------------------------------------------------------------------------
module pbrs_qtab (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [pbrs_pkg::PRIO_W-1:0]   waddr,
	input  pbrs_pkg::qent_t               wdata,
	input  logic [pbrs_pkg::PRIO_W-1:0]   raddr,
	output pbrs_pkg::qent_t               rdata
);
	import pbrs_pkg::*;

	qent_t                     mem [NUM_PRIORITIES];
	logic [NUM_PRIORITIES-1:0] vld_q;
	qent_t                     rdata_q;

	// Written flags stand in for the zero reset of the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// Storage and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= vld_q[raddr] ? mem[raddr] : '0;
	end

	assign rdata = rdata_q;

endmodule

### design/pbrs_ttab.sv
// ----------------------------------------------------------------------------
// pbrs_ttab: per-thread link and priority table
// One write with per-field enables and one registered read per cycle. The
// priority field reads its reset value until written; the links have none.
// ----------------------------------------------------------------------------
module pbrs_ttab (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pbrs_pkg::twe_t               we,
	input  logic [pbrs_pkg::TID_W-1:0]   waddr,
	input  pbrs_pkg::tent_t              wdata,
	input  logic [pbrs_pkg::TID_W-1:0]   raddr,
	output pbrs_pkg::tent_t              rdata
);
	import pbrs_pkg::*;

	tent_t                  mem [NUM_THREADS];
	logic [NUM_THREADS-1:0] pvld_q;
	tent_t                  rdata_q;

	// Priority written flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_q <= '0;
		end else if (we.prio) begin
			pvld_q[waddr] <= 1'b1;
		end
	end

	// Field writes and registered read; an unwritten priority reads its
	// reset value (least urgent for the idle thread, zero otherwise).
	always_ff @(posedge clk) begin
		if (we.next) begin
			mem[waddr].next <= wdata.next;
		end
		if (we.prev) begin
			mem[waddr].prev <= wdata.prev;
		end
		if (we.prio) begin
			mem[waddr].prio <= wdata.prio;
		end
		rdata_q.next <= mem[raddr].next;
		rdata_q.prev <= mem[raddr].prev;
		rdata_q.prio <= pvld_q[raddr] ? mem[raddr].prio :
			((raddr == IDLE_THREAD) ? IDLE_PRIO : '0);
	end

	assign rdata = rdata_q;

endmodule

### design/priority_bitmap_ready_scheduler.sv
// ----------------------------------------------------------------------------
// priority_bitmap_ready_scheduler: bitmap ready-queue scheduler
// A request is taken when start is high and busy is low. The result beat is
// shown on rsp for one cycle with done high and cannot be held off by the
// receiver; a new request may be accepted in that same cycle. The request walks
// the queue table and the thread table, each a memory with one write port and
// one registered read port: an insert into a non-empty queue also links the
// old tail, a remove from the middle of a queue also relinks the next thread,
// a schedule first reads the head of the most urgent queue and then removes it,
// and a rejected or no-op request goes straight to the result. boot_priority
// is written on the cfg channel, which is ready while busy and start are low.
// ----------------------------------------------------------------------------
module priority_bitmap_ready_scheduler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  pbrs_pkg::req_t                req,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pbrs_pkg::PRIO_W-1:0]   cfg_data,
	output logic                          done,
	output pbrs_pkg::rsp_t                rsp
);
	import pbrs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_LINK,
		ST_INS_NEXT,
		ST_SCH_Q,
		ST_UNL_T,
		ST_UNL_Q,
		ST_UNL_MID,
		ST_DONE
	} state_t;

	state_t                    state_q;
	logic [NUM_PRIORITIES-1:0] map_q;
	logic [NUM_THREADS-1:0]    queued_q;
	logic [TID_W-1:0]          cur_q;
	logic [PRIO_W-1:0]         cur_prio_q;
	logic [TID_W-1:0]          prev_q;
	logic [TID_W-1:0]          tid_q;
	logic [PRIO_W-1:0]         pri_q;
	logic [TID_W-1:0]          ut_q;
	logic                      sched_q;
	logic [TID_W-1:0]          nx_q;
	logic [TID_W-1:0]          pv_q;
	logic [PRIO_W-1:0]         up_q;
	logic [TID_W-1:0]          tl_q;
	logic                      status_q;
	logic                      switched_q;
	logic                      done_q;
	rsp_t                      rsp_q;

	logic              q_we;
	logic [PRIO_W-1:0] q_waddr;
	qent_t             q_wdata;
	logic [PRIO_W-1:0] q_raddr;
	qent_t             q_rdata;
	twe_t              t_we;
	logic [TID_W-1:0]  t_waddr;
	tent_t             t_wdata;
	logic [TID_W-1:0]  t_raddr;
	tent_t             t_rdata;

	logic              accept;
	logic              cfg_wr;
	logic [PRIO_W-1:0] in_pri;
	logic [PRIO_W-1:0] cfg_prio;
	logic [PRIO_W-1:0] top_prio;
	logic              at_head;
	logic              at_tail;
	state_t            acc_state;
	logic              acc_status;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy && !start;
	assign accept    = start && !busy;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign in_pri    = clamp_prio(req.priority_req);
	assign cfg_prio  = clamp_prio(cfg_data);
	assign top_prio  = lowest_set(map_q);
	assign at_head   = (q_rdata.head == ut_q);
	assign at_tail   = (q_rdata.tail == ut_q);

	// Tables. The sequencer runs one request at a time, so a read whose data is
	// used never overlaps a write to the same entry.
	pbrs_qtab u_qtab (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (q_we),
		.waddr  (q_waddr),
		.wdata  (q_wdata),
		.raddr  (q_raddr),
		.rdata  (q_rdata)
	);

	pbrs_ttab u_ttab (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (t_we),
		.waddr  (t_waddr),
		.wdata  (t_wdata),
		.raddr  (t_raddr),
		.rdata  (t_rdata)
	);

	// First step and early status of an incoming request.
	always_comb begin
		acc_state  = ST_DONE;
		acc_status = 1'b0;
		unique case (req.req_type)
			REQ_INSERT: begin
				if (queued_q[req.thread_id]) begin
					acc_status = 1'b1;
				end else begin
					acc_state = ST_INS_LINK;
				end
			end
			REQ_REMOVE: begin
				// Removing the running thread is a silent no-op.
				if (req.thread_id != cur_q) begin
					if (!queued_q[req.thread_id]) begin
						acc_status = 1'b1;
					end else begin
						acc_state = ST_UNL_T;
					end
				end
			end
			REQ_SCHED: begin
				if (map_q != '0 && top_prio <= cur_prio_q) begin
					acc_state = ST_SCH_Q;
				end
			end
			default: begin
				acc_status = 1'b1;
			end
		endcase
	end

	// Table addresses and write data for each step.
	always_comb begin
		q_we    = 1'b0;
		q_waddr = pri_q;
		q_wdata = '{head: tid_q, tail: tid_q};
		q_raddr = in_pri;
		t_we    = '0;
		t_waddr = tid_q;
		t_wdata = '{next: tid_q, prev: q_rdata.tail, prio: pri_q};
		t_raddr = req.thread_id;
		unique case (state_q)
			ST_IDLE: begin
				if (req.req_type == REQ_SCHED) begin
					q_raddr = top_prio;
				end
				t_we.prio    = cfg_wr;
				t_waddr      = BOOT_THREAD;
				t_wdata.prio = cfg_prio;
			end
			ST_INS_LINK: begin
				q_we         = 1'b1;
				q_wdata.head = map_q[pri_q] ? q_rdata.head : tid_q;
				t_we.prio    = 1'b1;
				t_we.prev    = map_q[pri_q];
			end
			ST_INS_NEXT: begin
				t_waddr      = tl_q;
				t_we.next    = 1'b1;
				t_wdata.next = tid_q;
			end
			ST_SCH_Q: begin
				t_raddr = q_rdata.head;
			end
			ST_UNL_T: begin
				q_raddr = t_rdata.prio;
			end
			ST_UNL_Q: begin
				q_waddr = up_q;
				if (at_head && !at_tail) begin
					q_we    = 1'b1;
					q_wdata = '{head: nx_q, tail: q_rdata.tail};
				end else if (!at_head && at_tail) begin
					q_we    = 1'b1;
					q_wdata = '{head: q_rdata.head, tail: pv_q};
				end else if (!at_head && !at_tail) begin
					t_waddr      = pv_q;
					t_we.next    = 1'b1;
					t_wdata.next = nx_q;
				end
			end
			ST_UNL_MID: begin
				t_waddr      = nx_q;
				t_we.prev    = 1'b1;
				t_wdata.prev = pv_q;
			end
			default: begin
			end
		endcase
	end

	// Request sequencer, scheduler state and the registered result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			map_q      <= NUM_PRIORITIES'(1) << IDLE_PRIO;
			queued_q   <= NUM_THREADS'(1) << IDLE_THREAD;
			cur_q      <= BOOT_THREAD;
			cur_prio_q <= '0;
			prev_q     <= '0;
			tid_q      <= '0;
			pri_q      <= '0;
			ut_q       <= '0;
			sched_q    <= 1'b0;
			nx_q       <= '0;
			pv_q       <= '0;
			up_q       <= '0;
			tl_q       <= '0;
			status_q   <= 1'b0;
			switched_q <= 1'b0;
			done_q     <= 1'b0;
			rsp_q      <= '0;
		end else begin
			done_q <= (state_q == ST_DONE);
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_wr && cur_q == BOOT_THREAD) begin
						cur_prio_q <= cfg_prio;
					end
					if (accept) begin
						prev_q     <= cur_q;
						tid_q      <= req.thread_id;
						pri_q      <= in_pri;
						ut_q       <= req.thread_id;
						sched_q    <= 1'b0;
						status_q   <= acc_status;
						switched_q <= 1'b0;
						state_q    <= acc_state;
					end
				end
				ST_INS_LINK: begin
					tl_q            <= q_rdata.tail;
					map_q[pri_q]    <= 1'b1;
					queued_q[tid_q] <= 1'b1;
					if (tid_q == cur_q) begin
						cur_prio_q <= pri_q;
					end
					state_q <= map_q[pri_q] ? ST_INS_NEXT : ST_DONE;
				end
				ST_INS_NEXT: begin
					state_q <= ST_DONE;
				end
				ST_SCH_Q: begin
					ut_q    <= q_rdata.head;
					sched_q <= 1'b1;
					state_q <= ST_UNL_T;
				end
				ST_UNL_T: begin
					up_q    <= t_rdata.prio;
					nx_q    <= t_rdata.next;
					pv_q    <= t_rdata.prev;
					state_q <= ST_UNL_Q;
				end
				ST_UNL_Q: begin
					queued_q[ut_q] <= 1'b0;
					if (sched_q) begin
						cur_q      <= ut_q;
						cur_prio_q <= up_q;
						switched_q <= (ut_q != prev_q);
					end
					if (at_head && at_tail) begin
						map_q[up_q] <= 1'b0;
					end
					state_q <= (!at_head && !at_tail) ? ST_UNL_MID : ST_DONE;
				end
				ST_UNL_MID: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					rsp_q.status         <= status_q;
					rsp_q.switched       <= switched_q;
					rsp_q.prev_thread    <= prev_q;
					rsp_q.running_thread <= cur_q;
					rsp_q.top_priority   <= (map_q != '0) ? top_prio : '0;
					rsp_q.preempt_ready  <= (map_q != '0) && (top_prio <= cur_prio_q);
					state_q              <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// A result beat always follows the closing step of a request.
	a_done_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(state_q == ST_DONE))
		else $error("result beat without a closing step");

	// A switch names a different thread and is never a rejected request.
	a_switch_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.switched |-> rsp.running_thread != rsp.prev_thread && !rsp.status)
		else $error("switch beat inconsistent");

	// The second link write of a middle unlink follows the first.
	a_mid_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UNL_MID |-> $past(state_q == ST_UNL_Q))
		else $error("middle unlink out of order");

	// The running thread changes only through a schedule dequeue.
	a_cur_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cur_q) |-> $past(state_q == ST_UNL_Q && sched_q))
		else $error("running thread changed outside a schedule");

endmodule
